// File: design/stts_pkg.sv
// Shared types, constants and helpers for the sighting table with threat score.
package stts_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned TIME_W = 63;
  localparam int unsigned IVL_W = 40;
  localparam int unsigned SCORE_W = 16;

  localparam logic [3:0] PERSIST_CLASS = 4'd15;
  localparam logic [SCORE_W-1:0] LEVEL_ALERT_AT = 16'd6;
  localparam logic [SCORE_W-1:0] LEVEL_CAUTION_AT = 16'd3;

  localparam logic [1:0] FUNC_OBS = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_STATUS = 2'd2;
  localparam logic [1:0] FUNC_RESERVED = 2'd3;

  localparam logic [3:0] REG_SIGNAL_FLOOR = 4'd0;
  localparam logic [3:0] REG_DECAY_IVL = 4'd1;
  localparam logic [3:0] REG_COOLDOWN = 4'd2;
  localparam logic [3:0] REG_CEILING = 4'd3;
  localparam logic [3:0] REG_EXPIRY = 4'd4;
  localparam logic [3:0] REG_MIN_HITS = 4'd5;
  localparam logic [3:0] REG_MIN_SPAN = 4'd6;
  localparam logic [3:0] REG_PERSIST_PTS = 4'd7;

  typedef struct packed {
    logic       source;
    logic [7:0] channel;
    logic [7:0] points;
    logic [3:0] cls;
  } meta_t;

  typedef struct packed {
    logic [47:0]       addr;
    logic [TIME_W-1:0] first_seen;
    logic [TIME_W-1:0] last_seen;
    logic [TIME_W-1:0] last_scored;
    logic              scored_once;
    logic [31:0]       hits;
    logic [7:0]        best_rssi;
    meta_t             meta;
  } entry_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] quot;
    logic [IVL_W-1:0]  rem;
  } div_res_t;

  function automatic logic [1:0] level_of(logic [SCORE_W-1:0] s);
    logic [1:0] l;
    if (s >= LEVEL_ALERT_AT) l = 2'd2;
    else if (s >= LEVEL_CAUTION_AT) l = 2'd1;
    else l = 2'd0;
    return l;
  endfunction

endpackage

// File: design/stts_decay_div.sv
// Bit-serial restoring divider: elapsed time over the decay interval.
module stts_decay_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [stts_pkg::TIME_W-1:0]       dividend_i,
  input  logic [stts_pkg::IVL_W-1:0]        divisor_i,
  output stts_pkg::div_res_t                res_o
);

  logic                            busy_q;
  logic                            done_q;
  logic [5:0]                      step_q;
  logic [stts_pkg::TIME_W-1:0]     dvd_q;
  logic [stts_pkg::TIME_W-1:0]     quot_q;
  logic [stts_pkg::IVL_W-1:0]      rem_q;
  logic [stts_pkg::IVL_W:0]        trial;
  logic                            fits;

  assign trial = {rem_q, dvd_q[stts_pkg::TIME_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      dvd_q  <= '0;
      quot_q <= '0;
      rem_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
      dvd_q  <= dividend_i;
      quot_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[stts_pkg::TIME_W-2:0], 1'b0};
      quot_q <= {quot_q[stts_pkg::TIME_W-2:0], fits};
      rem_q  <= fits ? stts_pkg::IVL_W'(trial - {1'b0, divisor_i})
                     : trial[stts_pkg::IVL_W-1:0];
      step_q <= step_q + 6'd1;
      if (step_q == 6'(stts_pkg::TIME_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign res_o = '{done: done_q, quot: quot_q, rem: rem_q};

endmodule

// File: design/sighting_table_with_threat_score.sv
// Top level: device sighting table with global threat score.
// - Input channel (in_valid_i / in_stall_o): one item per request; func_i picks
//   observation, tick (expiry sweep) or status query. in_stall_o is low only
//   while the engine is idle; an item may enter while the previous result still
//   sits in the output register.
// - Output channel (out_valid_o / out_stall_i): exactly one result item per
//   input item, held steady while stalled. If the output register is still
//   full and stalled at the next result, the engine waits in its final state.
// - Config: cfg_we_i writes register cfg_index_i with cfg_wdata_i;
//   write only while idle.
// - Sequence: a dropped observation or an unused func code goes straight to
//   the final state. An accepted observation sweeps all 64 entries through
//   the single table RAM read port, then applies decay and fetches the chosen
//   entry, does one read-modify-write and loads the result. Tick and status
//   skip the write. The decay divider runs beside the sweep; the decay state
//   waits for its quotient. The input reopens as the result becomes valid.
// - Reset: used/classified flags live in flip-flops and clear at once; the
//   RAM needs no clearing pass since an unused entry is never read for data.
//   Score, decay mark, sighting counter clear; registers take their defaults.
module sighting_table_with_threat_score (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [62:0] time_us_i,
  input  logic [47:0] device_addr_i,
  input  logic signed [7:0] signal_dbm_i,
  input  logic        from_ble_i,
  input  logic [7:0]  radio_channel_i,
  input  logic        known_class_valid_i,
  input  logic [3:0]  known_class_i,
  input  logic [7:0]  known_points_i,
  input  logic        muted_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        reportable_o,
  output logic [15:0] threat_score_o,
  output logic [1:0]  threat_level_o,
  output logic [31:0] sightings_total_o,
  output logic [6:0]  classified_count_o,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [39:0] cfg_wdata_i
);

  localparam int unsigned N = stts_pkg::TABLE_ENTRIES;
  localparam int unsigned IW = stts_pkg::IDX_W;
  localparam int unsigned CW = stts_pkg::CNT_W;
  localparam int unsigned TW = stts_pkg::TIME_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DECAY = 5'b00100,
    ST_UPD   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic signed [7:0] floor_q;
  logic [39:0] ivl_q, cool_q, expiry_q, span_q;
  logic [15:0] ceil_q, min_hits_q;
  logic [7:0]  ppts_q;

  // latched item
  logic [1:0]  func_q;
  logic [TW-1:0] now_q;
  logic [47:0] addr_q;
  logic signed [7:0] rssi_q;
  logic ble_q, kv_q;
  logic [7:0] chan_q, kp_q;
  logic [3:0] kc_q;

  // global state
  logic [15:0] score_q;
  logic [TW-1:0] mark_q;
  logic [31:0] sightings_q;
  logic [N-1:0] used_q, cls_q;

  // sweep bookkeeping
  logic [CW-1:0] issue_q;
  logic          rv_q;
  logic [IW-1:0] ri_q;
  logic          hit_f_q, free_f_q, uc_f_q, old_f_q;
  logic [IW-1:0] hit_i_q, free_i_q, uc_i_q, old_i_q;
  logic [TW-1:0] uc_ls_q, old_ls_q;
  logic [CW-1:0] ccnt_q;
  logic [IW-1:0] e_q;
  logic          new_q;

  // result staging and output
  logic rep_q;
  logic out_valid_q, out_rep_q;
  logic [15:0] out_score_q;
  logic [1:0]  out_level_q;
  logic [31:0] out_sight_q;
  logic [6:0]  out_cc_q;

  // table RAM
  stts_pkg::entry_t mem [N];
  stts_pkg::entry_t rdata_q;
  logic [IW-1:0]    rd_addr;
  logic             wr_en;
  stts_pkg::entry_t wr_data;

  // divider
  stts_pkg::div_res_t dres;
  logic               div_start;
  logic [39:0]        ivl_eff;

  logic accept, drop, fin_ok;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign drop = (func_i == stts_pkg::FUNC_OBS) &&
                (muted_i || (signal_dbm_i != 8'sd0 && signal_dbm_i < floor_q));
  assign ivl_eff = (ivl_q == '0) ? 40'd1 : ivl_q;
  assign div_start = accept && !drop && (func_i != stts_pkg::FUNC_RESERVED);
  assign fin_ok = !out_valid_q || !out_stall_i;

  stts_decay_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (TW'(time_us_i - mark_q)),
    .divisor_i  (ivl_eff),
    .res_o      (dres)
  );

  // sweep: evaluate the entry returned by the RAM this cycle
  stts_pkg::entry_t sent;
  logic s_used, s_cls, s_match, s_expire;
  assign sent    = rdata_q;
  assign s_used  = used_q[ri_q];
  assign s_cls   = cls_q[ri_q];
  assign s_match = s_used && (sent.addr == addr_q);
  assign s_expire = s_used && (now_q > sent.last_seen) &&
                    (TW'(now_q - sent.last_seen) > {{(TW-40){1'b0}}, expiry_q});

  // decay application
  logic [15:0] dec_score;
  logic [TW-1:0] dec_mark;
  logic [IW-1:0] pick;
  always_comb begin
    dec_score = score_q;
    dec_mark  = mark_q;
    if (score_q == '0) begin
      dec_mark = now_q;
    end else if (now_q >= mark_q) begin
      if (dres.quot >= {{(TW-16){1'b0}}, score_q}) begin
        dec_score = '0;
        dec_mark  = now_q;
      end else begin
        dec_score = score_q - dres.quot[15:0];
        dec_mark  = now_q - {{(TW-40){1'b0}}, dres.rem};
      end
    end
    priority if (hit_f_q) pick = hit_i_q;
    else if (free_f_q) pick = free_i_q;
    else if (uc_f_q) pick = uc_i_q;
    else pick = old_i_q;
  end

  // entry update
  stts_pkg::entry_t base, upd;
  logic c_old, persist, c_new, blocked, do_score;
  logic [16:0] sum;
  logic [15:0] new_score;
  always_comb begin
    base = new_q ? '0 : rdata_q;
    c_old = new_q ? 1'b0 : cls_q[e_q];
    upd = base;
    upd.addr = addr_q;
    upd.hits = base.hits + 32'd1;
    upd.last_seen = now_q;
    if (new_q) upd.first_seen = now_q;
    upd.meta.channel = chan_q;
    upd.meta.source = ble_q;
    if (rssi_q != 8'sd0 && (base.best_rssi == '0 ||
        rssi_q > $signed(base.best_rssi))) begin
      upd.best_rssi = rssi_q;
    end
    persist = !kv_q && !c_old && ble_q &&
              (upd.hits >= {16'd0, min_hits_q}) &&
              (now_q >= upd.first_seen) &&
              (TW'(now_q - upd.first_seen) >= {{(TW-40){1'b0}}, span_q});
    if (kv_q) begin
      upd.meta.cls = kc_q;
      upd.meta.points = kp_q;
    end else if (persist) begin
      upd.meta.cls = stts_pkg::PERSIST_CLASS;
      upd.meta.points = ppts_q;
    end
    c_new = kv_q || c_old || persist;
    blocked = base.scored_once && ((now_q < base.last_scored) ||
              (TW'(now_q - base.last_scored) < {{(TW-40){1'b0}}, cool_q}));
    do_score = c_new && (upd.meta.points != '0) && !blocked;
    sum = {1'b0, score_q} + {9'd0, upd.meta.points};
    new_score = (sum > {1'b0, ceil_q}) ? ceil_q : sum[15:0];
    if (do_score) begin
      upd.scored_once = 1'b1;
      upd.last_scored = now_q;
    end
  end

  assign wr_en = (state_q == ST_UPD);
  assign wr_data = upd;
  assign rd_addr = (state_q == ST_DECAY) ? pick : issue_q[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[e_q] <= wr_data;
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = div_start ? ST_SCAN : ST_FIN;
      ST_SCAN:  if (rv_q && ri_q == IW'(N - 1)) state_d = ST_DECAY;
      ST_DECAY: if (dres.done) state_d = (func_q == stts_pkg::FUNC_OBS) ? ST_UPD : ST_FIN;
      ST_UPD:   state_d = ST_FIN;
      ST_FIN:   if (fin_ok) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      floor_q <= -8'sd90;
      ivl_q <= 40'd10000000;
      cool_q <= 40'd60000000;
      ceil_q <= 16'd10;
      expiry_q <= 40'd300000000;
      min_hits_q <= 16'd5;
      span_q <= 40'd60000000;
      ppts_q <= 8'd2;
      func_q <= '0; now_q <= '0; addr_q <= '0; rssi_q <= '0; ble_q <= 1'b0;
      kv_q <= 1'b0; chan_q <= '0; kp_q <= '0; kc_q <= '0;
      score_q <= '0; mark_q <= '0; sightings_q <= '0;
      used_q <= '0; cls_q <= '0;
      issue_q <= '0; rv_q <= 1'b0; ri_q <= '0;
      hit_f_q <= 1'b0; free_f_q <= 1'b0; uc_f_q <= 1'b0; old_f_q <= 1'b0;
      hit_i_q <= '0; free_i_q <= '0; uc_i_q <= '0; old_i_q <= '0;
      uc_ls_q <= '0; old_ls_q <= '0; ccnt_q <= '0; e_q <= '0; new_q <= 1'b0;
      rep_q <= 1'b0;
      out_valid_q <= 1'b0; out_rep_q <= 1'b0; out_score_q <= '0;
      out_level_q <= '0; out_sight_q <= '0; out_cc_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          stts_pkg::REG_SIGNAL_FLOOR: floor_q <= cfg_wdata_i[7:0];
          stts_pkg::REG_DECAY_IVL:    ivl_q <= cfg_wdata_i;
          stts_pkg::REG_COOLDOWN:     cool_q <= cfg_wdata_i;
          stts_pkg::REG_CEILING:      ceil_q <= cfg_wdata_i[15:0];
          stts_pkg::REG_EXPIRY:       expiry_q <= cfg_wdata_i;
          stts_pkg::REG_MIN_HITS:     min_hits_q <= cfg_wdata_i[15:0];
          stts_pkg::REG_MIN_SPAN:     span_q <= cfg_wdata_i;
          stts_pkg::REG_PERSIST_PTS:  ppts_q <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      // in the final state the result load below owns the valid flag
      if (out_valid_q && !out_stall_i && state_q != ST_FIN) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            func_q <= func_i; now_q <= time_us_i; addr_q <= device_addr_i;
            rssi_q <= signal_dbm_i; ble_q <= from_ble_i; chan_q <= radio_channel_i;
            kv_q <= known_class_valid_i; kc_q <= known_class_i; kp_q <= known_points_i;
            rep_q <= 1'b0;
            issue_q <= '0; rv_q <= 1'b0; ccnt_q <= '0;
            hit_f_q <= 1'b0; free_f_q <= 1'b0; uc_f_q <= 1'b0; old_f_q <= 1'b0;
            if (div_start && func_i == stts_pkg::FUNC_OBS) sightings_q <= sightings_q + 32'd1;
          end
        end
        ST_SCAN: begin
          if (issue_q != CW'(N)) issue_q <= issue_q + CW'(1);
          rv_q <= (issue_q != CW'(N));
          ri_q <= issue_q[IW-1:0];
          if (rv_q) begin
            if (s_match && !hit_f_q) begin
              hit_f_q <= 1'b1; hit_i_q <= ri_q;
            end
            if (!s_used && !free_f_q) begin
              free_f_q <= 1'b1; free_i_q <= ri_q;
            end
            if (s_used && !s_cls && (!uc_f_q || sent.last_seen < uc_ls_q)) begin
              uc_f_q <= 1'b1; uc_i_q <= ri_q; uc_ls_q <= sent.last_seen;
            end
            if (s_used && (!old_f_q || sent.last_seen < old_ls_q)) begin
              old_f_q <= 1'b1; old_i_q <= ri_q; old_ls_q <= sent.last_seen;
            end
            if (func_q == stts_pkg::FUNC_STATUS && s_used && s_cls)
              ccnt_q <= ccnt_q + CW'(1);
            if (func_q == stts_pkg::FUNC_TICK && s_expire) begin
              used_q[ri_q] <= 1'b0;
              cls_q[ri_q] <= 1'b0;
            end
          end
        end
        ST_DECAY: begin
          if (dres.done) begin
            score_q <= dec_score;
            mark_q <= dec_mark;
            e_q <= pick;
            new_q <= !hit_f_q;
          end
        end
        ST_UPD: begin
          used_q[e_q] <= 1'b1;
          cls_q[e_q] <= c_new;
          rep_q <= c_new;
          if (do_score) score_q <= new_score;
        end
        ST_FIN: begin
          if (fin_ok) begin
            out_valid_q <= 1'b1;
            out_rep_q <= rep_q;
            out_score_q <= score_q;
            out_level_q <= stts_pkg::level_of(score_q);
            out_sight_q <= sightings_q;
            out_cc_q <= (func_q == stts_pkg::FUNC_STATUS) ? 7'(ccnt_q) : 7'd0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign reportable_o = out_rep_q;
  assign threat_score_o = out_score_q;
  assign threat_level_o = out_level_q;
  assign sightings_total_o = out_sight_q;
  assign classified_count_o = out_cc_q;

  // a classified flag never outlives its entry
  a_cls_implies_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cls_q & ~used_q) == '0) else $error("classified flag on free entry");

  // decay is only applied with a finished quotient
  a_div_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> dres.done) else $error("update before divider finished");

  // the sighting counter moves only on an accepted observation
  a_sight_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(sightings_q) |-> $past(accept && func_i == stts_pkg::FUNC_OBS))
    else $error("sighting counter changed without an observation");

endmodule
